[src/wrast_pkg.sv]
package wrast_pkg;

  localparam int LEAVES = 65536;
  localparam int LOG    = $clog2(LEAVES);
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = LOG + 1;
  localparam int PTR_W  = LOG + 2;
  localparam int CNT_W  = LOG + 1;
  localparam int LVL_W  = $clog2(LOG + 1);
  localparam int VAL_W  = 30;

  localparam logic [VAL_W-1:0] MODP = 30'd998244353;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_SUM  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [15:0]      left_index;
    logic [15:0]      right_index;
    logic [VAL_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] range_total;
    logic             range_invalid;
  } res_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] weight;
    logic [VAL_W-1:0] pending;
  } node_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODP}) begin
      s = s - {1'b0, MODP};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

[src/wrast_ram.sv]
module wrast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wrast_mulmod.sv]
module wrast_mulmod
  import wrast_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [VAL_W-1:0] prod
);

  logic [VAL_W-1:0]         sh;
  logic [VAL_W-1:0]         bb;
  logic [$clog2(VAL_W)-1:0] cnt;
  logic                     run;
  logic [VAL_W:0]           dbl;
  logic [VAL_W:0]           dbl_r;
  logic [VAL_W:0]           sum;
  logic [VAL_W-1:0]         step;

  // one multiplier bit per cycle, msb first
  always_comb begin
    dbl   = {prod, 1'b0};
    dbl_r = (dbl >= {1'b0, MODP}) ? dbl - {1'b0, MODP} : dbl;
    sum   = dbl_r + (sh[VAL_W-1] ? {1'b0, bb} : '0);
    if (sum >= {1'b0, MODP}) begin
      sum = sum - {1'b0, MODP};
    end
    step = sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= ($clog2(VAL_W))'(VAL_W - 1);
        sh   <= a;
        bb   <= b;
        prod <= '0;
      end else if (run) begin
        prod <= step;
        sh   <= sh << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/weighted_range_add_sum_tree.sv]
// Weighted range-add / range-sum tree, arithmetic modulo 998244353.
// Requests enter on start/request, taken at an edge with start high and
// busy low. request.req_type selects a weight load, a range add or a range
// sum query. Only a query gives a result: result is shown for one cycle
// with result_valid high and the receiver cannot stall it.
// leaf_count is written on cfg_valid/cfg_ready (always ready); the user
// must write it only while idle, which the block does not enforce. After
// reset the node store is cleared one entry a cycle: busy stays high until
// all 131072 entries are cleared. A request walks the tree top-down pushing
// pending tags; an add or query then applies at the covering nodes, and an
// add pulls sums back up; a load adds its weight at each node from leaf to
// root. Node updates are read-modify-writes of the one node memory; each
// tag waits on a 30-step serial modular multiply. Request time is set by the
// number of pushed and tagged nodes; one request is in work at a time.
// An invalid query gives its result the cycle after it is taken.
module weighted_range_add_sum_tree
  import wrast_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             result_valid,
  output res_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_P0   = 5'd3;
  localparam logic [4:0] S_P1   = 5'd4;
  localparam logic [4:0] S_C0   = 5'd5;
  localparam logic [4:0] S_C1   = 5'd6;
  localparam logic [4:0] S_C2   = 5'd7;
  localparam logic [4:0] S_P2   = 5'd8;
  localparam logic [4:0] S_U0   = 5'd9;
  localparam logic [4:0] S_U1   = 5'd10;
  localparam logic [4:0] S_U2   = 5'd11;
  localparam logic [4:0] S_U3   = 5'd12;
  localparam logic [4:0] S_Q0   = 5'd13;
  localparam logic [4:0] S_Q1   = 5'd14;
  localparam logic [4:0] S_W0   = 5'd15;
  localparam logic [4:0] S_W1   = 5'd16;

  localparam logic [2:0] PH_PUSH  = 3'd0;
  localparam logic [2:0] PH_WADD  = 3'd1;
  localparam logic [2:0] PH_APPLY = 3'd2;
  localparam logic [2:0] PH_UPD   = 3'd3;
  localparam logic [2:0] PH_END   = 3'd4;

  logic [4:0]        state;
  logic [2:0]        phase;
  logic [1:0]        kind;
  logic [PTR_W-1:0]  lo;
  logic [PTR_W-1:0]  hi;
  logic [PTR_W-1:0]  cl;
  logic [PTR_W-1:0]  cr;
  logic [LVL_W-1:0]  lvl;
  logic              side;
  logic              sub;
  logic [VAL_W-1:0]  x;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  fac;
  logic [VAL_W-1:0]  ua;
  logic [VAL_W-1:0]  ub;
  logic              tag_push;
  logic [NODE_W-1:0] tgt;
  logic [NODE_W-1:0] cad;
  logic [NODE_W-1:0] clr_addr;
  node_t             par;
  node_t             crec;
  logic [CNT_W-1:0]  leaf_count;

  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  node_t             mem_wdata;
  logic [NODE_W-1:0] mem_raddr;
  node_t             mem_rdata;

  logic              mul_start;
  logic              mul_done;
  logic [VAL_W-1:0]  mul_prod;

  logic [CNT_W-1:0]  eff;
  logic              bad;
  logic [VAL_W-1:0]  amt;
  logic [PTR_W-1:0]  mask;
  logic [PTR_W-1:0]  lo_sh;
  logic [PTR_W-1:0]  hi_sh;

  wrast_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(NODES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  wrast_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (fac),
    .b    (mem_rdata.weight),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    eff   = (leaf_count > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : leaf_count;
    bad   = (request.left_index > request.right_index) ||
            ({1'b0, request.right_index} >= eff);
    amt   = (request.amount >= MODP) ? request.amount - MODP : request.amount;
    mask  = ~({PTR_W{1'b1}} << lvl);
    lo_sh = lo >> lvl;
    hi_sh = (hi - 1'b1) >> lvl;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt;
    mem_wdata = mem_rdata;
    mem_raddr = tgt;
    mul_start = 1'b0;
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_C0: mem_raddr = cad;
      S_C1: mul_start = 1'b1;
      S_C2: begin
        mem_we    = mul_done;
        mem_waddr = cad;
        mem_wdata = '{value:   mod_add(crec.value, mul_prod),
                      weight:  crec.weight,
                      pending: mod_add(crec.pending, fac)};
      end
      S_P2: begin
        mem_we    = 1'b1;
        mem_wdata = '{value: par.value, weight: par.weight, pending: '0};
      end
      S_U0: mem_raddr = {tgt[NODE_W-2:0], 1'b0};
      S_U1: mem_raddr = {tgt[NODE_W-2:0], 1'b1};
      S_U3: begin
        mem_we    = 1'b1;
        mem_wdata = '{value:   mod_add(ua, ub),
                      weight:  mem_rdata.weight,
                      pending: mem_rdata.pending};
      end
      S_W1: begin
        mem_we    = 1'b1;
        mem_wdata = '{value:   mem_rdata.value,
                      weight:  mod_add(mem_rdata.weight, x),
                      pending: mem_rdata.pending};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      leaf_count   <= CNT_W'(LEAVES);
      result_valid <= 1'b0;
      phase        <= PH_PUSH;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) begin
        leaf_count <= cfg_data;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {NODE_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind  <= request.req_type;
            lo    <= PTR_W'(LEAVES) + PTR_W'(request.left_index);
            hi    <= PTR_W'(LEAVES) + PTR_W'(request.right_index) + 1'b1;
            x     <= amt;
            acc   <= '0;
            phase <= PH_PUSH;
            lvl   <= LVL_W'(LOG);
            side  <= 1'b0;
            if (request.req_type == REQ_LOAD) begin
              if ({1'b0, request.left_index} < eff) begin
                state <= S_DISP;
              end
            end else if (request.req_type == REQ_ADD) begin
              if (!bad) begin
                state <= S_DISP;
              end
            end else if (request.req_type == REQ_SUM) begin
              if (bad) begin
                result_valid         <= 1'b1;
                result.range_total   <= '0;
                result.range_invalid <= 1'b1;
              end else begin
                state <= S_DISP;
              end
            end
          end
        end
        S_DISP: begin
          unique case (phase)
            PH_PUSH: begin
              if (!side && (kind == REQ_LOAD || (lo & mask) != '0)) begin
                tgt   <= lo_sh[NODE_W-1:0];
                state <= S_P0;
              end else if (side && (hi & mask) != '0) begin
                tgt   <= hi_sh[NODE_W-1:0];
                state <= S_P0;
              end
              if (!side && kind != REQ_LOAD) begin
                side <= 1'b1;
              end else begin
                side <= 1'b0;
                if (lvl == LVL_W'(1)) begin
                  if (kind == REQ_LOAD) begin
                    phase <= PH_WADD;
                    lvl   <= '0;
                  end else begin
                    phase <= PH_APPLY;
                    cl    <= lo;
                    cr    <= hi;
                    sub   <= 1'b0;
                  end
                end else begin
                  lvl <= lvl - 1'b1;
                end
              end
            end
            PH_WADD: begin
              tgt   <= lo_sh[NODE_W-1:0];
              state <= S_W0;
              if (lvl == LVL_W'(LOG)) begin
                phase <= PH_END;
              end else begin
                lvl <= lvl + 1'b1;
              end
            end
            PH_APPLY: begin
              if (!sub) begin
                if (cl >= cr) begin
                  if (kind == REQ_ADD) begin
                    phase <= PH_UPD;
                    lvl   <= LVL_W'(1);
                    side  <= 1'b0;
                  end else begin
                    phase <= PH_END;
                  end
                end else begin
                  sub <= 1'b1;
                  if (cl[0]) begin
                    tgt      <= cl[NODE_W-1:0];
                    cad      <= cl[NODE_W-1:0];
                    fac      <= x;
                    tag_push <= 1'b0;
                    cl       <= cl + 1'b1;
                    state    <= (kind == REQ_ADD) ? S_C0 : S_Q0;
                  end
                end
              end else begin
                sub <= 1'b0;
                cl  <= cl >> 1;
                cr  <= cr >> 1;
                if (cr[0]) begin
                  tgt      <= cl[NODE_W-1:0] ^ cl[NODE_W-1:0] ^ (cr[NODE_W-1:0] - 1'b1);
                  cad      <= cr[NODE_W-1:0] - 1'b1;
                  fac      <= x;
                  tag_push <= 1'b0;
                  state    <= (kind == REQ_ADD) ? S_C0 : S_Q0;
                end
              end
            end
            PH_UPD: begin
              if (!side && (lo & mask) != '0) begin
                tgt   <= lo_sh[NODE_W-1:0];
                state <= S_U0;
              end else if (side && (hi & mask) != '0) begin
                tgt   <= hi_sh[NODE_W-1:0];
                state <= S_U0;
              end
              side <= !side;
              if (side) begin
                if (lvl == LVL_W'(LOG)) begin
                  phase <= PH_END;
                end else begin
                  lvl <= lvl + 1'b1;
                end
              end
            end
            default: begin
              state <= S_IDLE;
              if (kind == REQ_SUM) begin
                result_valid         <= 1'b1;
                result.range_total   <= acc;
                result.range_invalid <= 1'b0;
              end
            end
          endcase
        end
        S_P0: state <= S_P1;
        S_P1: begin
          par      <= mem_rdata;
          fac      <= mem_rdata.pending;
          tag_push <= 1'b1;
          cad      <= {tgt[NODE_W-2:0], 1'b0};
          state    <= (mem_rdata.pending == '0) ? S_DISP : S_C0;
        end
        S_C0: state <= S_C1;
        S_C1: begin
          crec  <= mem_rdata;
          state <= S_C2;
        end
        S_C2: begin
          if (mul_done) begin
            if (tag_push && !cad[0]) begin
              cad   <= cad + 1'b1;
              state <= S_C0;
            end else if (tag_push) begin
              state <= S_P2;
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_P2: state <= S_DISP;
        S_U0: state <= S_U1;
        S_U1: begin
          ua    <= mem_rdata.value;
          state <= S_U2;
        end
        S_U2: begin
          ub    <= mem_rdata.value;
          state <= S_U3;
        end
        S_U3: state <= S_DISP;
        S_Q0: state <= S_Q1;
        S_Q1: begin
          acc   <= mod_add(acc, mem_rdata.value);
          state <= S_DISP;
        end
        S_W0: state <= S_W1;
        S_W1: state <= S_DISP;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
